// ===== rtl/gtem_pkg.sv =====
// shared types, constants and helpers of the gradient threshold edge map
// no dependencies
`default_nettype none

package gtem_pkg;

    // widest frame the row store can hold
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WCNT_W    = COL_W + 1;
    localparam int ROW_W     = 16;

    // configuration register widths
    localparam int THR_W     = 8;
    localparam int IMG_W_W   = 12;
    localparam int IMG_H_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd10;
    localparam logic [IMG_W_W-1:0] WIDTH_RST     = 12'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RST    = 16'd480;

    // divide by three as multiply by reciprocal, exact below 2048
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    typedef logic [COL_W-1:0]  col_t;
    typedef logic [WCNT_W-1:0] wcnt_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam rgb_t RGB_BLACK = '{r: 8'h00, g: 8'h00, b: 8'h00};
    localparam rgb_t RGB_WHITE = '{r: 8'hff, g: 8'hff, b: 8'hff};

    // row store access bundle
    typedef struct packed {
        logic rd_en;
        col_t rd_addr0;
        logic [COL_W-1:0] rd_addr1;
        logic wr_en;
        col_t wr_addr;
        rgb_t wr_data;
    } ls_req_t;

    // truncated mean of the three channels
    function automatic logic [7:0] gray_of(input rgb_t p);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = {2'b00, p.r} + {2'b00, p.g} + {2'b00, p.b};
        prod = {10'd0, sum} * {10'd0, DIV3_MUL};
        return prod[DIV3_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gradient_threshold_edge_map.sv =====
// top level of the gradient threshold edge map
// depends on gtem_pkg and gtem_line_store
//
// usage
//   pixels enter in raster order on red/green/blue under in_valid/in_ready;
//   result pixels leave on out_red/out_green/out_blue with last_of_run and
//   frame_end under out_valid/out_ready. the user writes threshold,
//   image_width and image_height through cfg_write_en/cfg_index/cfg_data
//   only while the block is idle, not enforced by it; index 3 is ignored.
// throughput and pipeline
//   one request per clock unless the output stage stalls. a pixel in row
//   y>=1 puts the result for the pixel above it on the outputs through the
//   row store read, the gray stage and the gradient stage. in the last
//   row each pixel yields two results, so the single output register holds
//   each such pixel until both have left. row 0 of a frame taller than
//   one row yields nothing.
// reset
//   counters and pipeline valids clear, registers return to threshold 10,
//   width 640, height 480. the row store is not cleared: a frame always
//   writes a row before it reads it.
// stalls
//   a stalled out_ready holds the result in the output stage while the two
//   stages before it keep filling; in_ready drops once all three are full.
`default_nettype none

module gradient_threshold_edge_map (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel input
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        red,
    input  wire logic [7:0]                        green,
    input  wire logic [7:0]                        blue,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [7:0]                             out_red,
    output logic [7:0]                             out_green,
    output logic [7:0]                             out_blue,
    output logic                                   last_of_run,
    output logic                                   frame_end,
    // configuration
    input  wire logic                              cfg_write_en,
    input  wire logic [gtem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gtem_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers, threshold kept squared for the compare
    // ------------------------------------------------------------------
    logic [gtem_pkg::THR_W-1:0]   thr_reg;
    logic [2*gtem_pkg::THR_W-1:0] thr_sq_reg;
    logic [gtem_pkg::IMG_W_W-1:0] width_reg;
    logic [gtem_pkg::IMG_H_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= gtem_pkg::THRESHOLD_RST;
            thr_sq_reg <= {8'd0, gtem_pkg::THRESHOLD_RST} * {8'd0, gtem_pkg::THRESHOLD_RST};
            width_reg  <= gtem_pkg::WIDTH_RST;
            height_reg <= gtem_pkg::HEIGHT_RST;
        end
        else if (cfg_write_en)
        begin
            case (gtem_pkg::cfg_reg_t'(cfg_index))
                gtem_pkg::REG_THRESHOLD:
                begin
                    thr_reg    <= cfg_data[gtem_pkg::THR_W-1:0];
                    thr_sq_reg <= {8'd0, cfg_data[gtem_pkg::THR_W-1:0]}
                                * {8'd0, cfg_data[gtem_pkg::THR_W-1:0]};
                end
                gtem_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[gtem_pkg::IMG_W_W-1:0];
                gtem_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[gtem_pkg::IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: each stage loads when empty or draining
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic en1, en2, en3;
    logic in_fire, out_fire, item_done;
    logic first;

    logic s3_has_above_reg, s3_lcol_reg, s3_lrow_reg, phase_reg;
    gtem_pkg::rgb_t s3_res_reg, s3_pix_reg;

    // first result of a last-row pixel is the one for the pixel above
    assign first     = s3_has_above_reg && !phase_reg;
    assign out_valid = s3_v_reg;
    assign out_fire  = out_valid && out_ready;
    assign item_done = out_fire && !(first && s3_lrow_reg);

    assign en3      = !s3_v_reg || item_done;
    assign en2      = !s2_v_reg || en3;
    assign en1      = !s1_v_reg || en2;
    assign in_ready = en1;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // raster position with the effective frame size
    // ------------------------------------------------------------------
    gtem_pkg::col_t  col_reg, col_next;
    gtem_pkg::row_t  row_reg, row_next;
    gtem_pkg::wcnt_t w_eff, col_ext, x_w;
    gtem_pkg::row_t  h_eff, y;
    gtem_pkg::col_t  x;
    logic            last_col, last_row, has_above;
    gtem_pkg::rgb_t  pix;

    assign pix = '{r: red, g: green, b: blue};

    always_comb
    begin
        // zero width means one column, oversized width saturates
        if (width_reg == '0)
        begin
            w_eff = gtem_pkg::wcnt_t'(1);
        end
        else if (32'(width_reg) > 32'(gtem_pkg::MAX_WIDTH))
        begin
            w_eff = gtem_pkg::wcnt_t'(gtem_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = gtem_pkg::wcnt_t'(width_reg);
        end

        h_eff = (height_reg == '0) ? gtem_pkg::row_t'(1) : height_reg;

        // a counter beyond a shrunk frame acts as the last column or row
        col_ext   = gtem_pkg::wcnt_t'(col_reg);
        x_w       = (col_ext >= w_eff) ? w_eff - gtem_pkg::wcnt_t'(1) : col_ext;
        x         = gtem_pkg::col_t'(x_w);
        y         = (row_reg >= h_eff) ? h_eff - gtem_pkg::row_t'(1) : row_reg;
        last_col  = (x_w == w_eff - gtem_pkg::wcnt_t'(1));
        last_row  = (y == h_eff - gtem_pkg::row_t'(1));
        has_above = (y != '0);

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : y + gtem_pkg::row_t'(1);
        end
        else
        begin
            col_next = x + gtem_pkg::col_t'(1);
            row_next = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // row store: read above and above-right, write this pixel back
    // ------------------------------------------------------------------
    gtem_pkg::ls_req_t ls_req;
    gtem_pkg::rgb_t    above_rd, right_rd;

    always_comb
    begin
        ls_req.rd_en    = in_fire;
        ls_req.rd_addr0 = x;
        ls_req.rd_addr1 = x + gtem_pkg::col_t'(1);
        ls_req.wr_en    = in_fire;
        ls_req.wr_addr  = x;
        ls_req.wr_data  = pix;
    end

    gtem_line_store u_line_store (
        .clk      (clk),
        .req      (ls_req),
        .rd_data0 (above_rd),
        .rd_data1 (right_rd)
    );

    // ------------------------------------------------------------------
    // stage 1: pixel and flags beside the row store read
    // pixels that give no result are dropped here
    // ------------------------------------------------------------------
    gtem_pkg::rgb_t s1_pix_reg;
    logic           s1_has_above_reg, s1_lcol_reg, s1_lrow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_v_reg <= in_fire && (has_above || last_row);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg       <= pix;
            s1_has_above_reg <= has_above;
            s1_lcol_reg      <= last_col;
            s1_lrow_reg      <= last_row;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: gray levels of above, above-right and this pixel
    // ------------------------------------------------------------------
    gtem_pkg::rgb_t s2_pix_reg, s2_above_reg;
    logic [7:0]     s2_g_above_reg, s2_g_right_reg, s2_g_pix_reg;
    logic           s2_has_above_reg, s2_lcol_reg, s2_lrow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_v_reg)
        begin
            s2_pix_reg       <= s1_pix_reg;
            s2_above_reg     <= above_rd;
            s2_g_above_reg   <= gtem_pkg::gray_of(above_rd);
            s2_g_right_reg   <= gtem_pkg::gray_of(right_rd);
            s2_g_pix_reg     <= gtem_pkg::gray_of(s1_pix_reg);
            s2_has_above_reg <= s1_has_above_reg;
            s2_lcol_reg      <= s1_lcol_reg;
            s2_lrow_reg      <= s1_lrow_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: squared gradient against squared threshold
    // ------------------------------------------------------------------
    logic signed [8:0]  dx, dy;
    logic        [17:0] dx_sq, dy_sq;
    logic        [17:0] mag2;
    gtem_pkg::rgb_t     res;

    always_comb
    begin
        dx    = $signed({1'b0, s2_g_right_reg}) - $signed({1'b0, s2_g_above_reg});
        dy    = $signed({1'b0, s2_g_pix_reg}) - $signed({1'b0, s2_g_above_reg});
        // sign-extend before squaring so the product keeps all its bits
        dx_sq = 18'(dx) * 18'(dx);
        dy_sq = 18'(dy) * 18'(dy);
        mag2  = dx_sq + dy_sq;
        // the last column has no right neighbour and passes through
        if (s2_lcol_reg)
        begin
            res = s2_above_reg;
        end
        else if (mag2 >= {2'b00, thr_sq_reg})
        begin
            res = gtem_pkg::RGB_BLACK;
        end
        else
        begin
            res = gtem_pkg::RGB_WHITE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            // step to the own pass-through once the above result is taken
            if (out_fire)
            begin
                phase_reg <= first && s3_lrow_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_v_reg)
        begin
            s3_res_reg       <= res;
            s3_pix_reg       <= s2_pix_reg;
            s3_has_above_reg <= s2_has_above_reg;
            s3_lcol_reg      <= s2_lcol_reg;
            s3_lrow_reg      <= s2_lrow_reg;
        end
    end

    // ------------------------------------------------------------------
    // output selection
    // ------------------------------------------------------------------
    always_comb
    begin
        if (first)
        begin
            out_red     = s3_res_reg.r;
            out_green   = s3_res_reg.g;
            out_blue    = s3_res_reg.b;
            last_of_run = !s3_lrow_reg;
            frame_end   = 1'b0;
        end
        else
        begin
            out_red     = s3_pix_reg.r;
            out_green   = s3_pix_reg.g;
            out_blue    = s3_pix_reg.b;
            last_of_run = 1'b1;
            frame_end   = s3_lcol_reg;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the second result is only pending for a last-row pixel with a row above
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (s3_v_reg && s3_has_above_reg && s3_lrow_reg))
        else $error("second result pending without a last-row item");

    // the frame's final result always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> last_of_run)
        else $error("frame_end without last_of_run");

    // the final pixel of a frame sends both counters back to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("raster counters did not wrap at frame end");

    // a threshold write keeps the squared copy in step
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write_en && cfg_index == gtem_pkg::REG_THRESHOLD)
        |=> (thr_sq_reg == {8'd0, thr_reg} * {8'd0, thr_reg}))
        else $error("squared threshold out of step");

endmodule

`default_nettype wire

// ===== rtl/gtem_line_store.sv =====
// row store of the edge map: one write port, two registered read ports
// depends on gtem_pkg
`default_nettype none

module gtem_line_store (
    input  wire                logic clk,
    input  wire gtem_pkg::ls_req_t   req,
    output gtem_pkg::rgb_t           rd_data0,
    output gtem_pkg::rgb_t           rd_data1
);

    gtem_pkg::rgb_t mem [gtem_pkg::MAX_WIDTH];

    // reads see the contents before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data0 <= mem[req.rd_addr0];
            rd_data1 <= mem[req.rd_addr1];
        end
    end

endmodule

`default_nettype wire
